// ===== design/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// Character canvas rasterizer package
// Shared types, sizes and command codes.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 128;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int AddrW = RowW + ColW;
  localparam logic [7:0] SpaceChar = 8'd32;

  localparam logic [2:0] ModeLine = 3'd0;
  localparam logic [2:0] ModeRing = 3'd1;
  localparam logic [2:0] ModeDisc = 3'd2;
  localparam logic [2:0] ModeRectLine = 3'd3;
  localparam logic [2:0] ModeRectFill = 3'd4;
  localparam logic [2:0] ModeClear = 3'd5;
  localparam logic [2:0] ModeRead = 3'd6;
  localparam logic [2:0] ModeNone = 3'd7;

  localparam logic RegRows = 1'b0;
  localparam logic RegCols = 1'b1;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [10:0] row_a;
    logic signed [10:0] col_a;
    logic signed [10:0] row_b;
    logic signed [10:0] col_b;
    logic [9:0]         radius;
    logic [7:0]         fill_char;
  } cmd_t;

endpackage

// ===== design/ccr_front.sv =====
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module ccr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ccr_pkg::cmd_t cmd_in,
  output logic          busy,
  output logic          q_valid,
  output ccr_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import ccr_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd2 && !q_pop) |=> busy)
    else $error("full queue not busy");
`endif
endmodule

// ===== design/ccr_engine.sv =====
// ----------------------------------------------------------------------------
// Drawing engine
// Runs one command at a time against the canvas memory: line stepping, cell
// scans for circles, rectangles and clear, and single-cell reads.
// ----------------------------------------------------------------------------
module ccr_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ccr_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic [6:0]    rows_in_use,
  input  logic [7:0]    cols_in_use,
  output logic          done,
  output logic [7:0]    cell_value,
  output logic          cell_in_range
);
  import ccr_pkg::*;

  localparam logic [3:0] StInit = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StLineSet = 4'd2;
  localparam logic [3:0] StLine = 4'd3;
  localparam logic [3:0] StScan = 4'd4;
  localparam logic [3:0] StScanW = 4'd5;
  localparam logic [3:0] StRead = 4'd6;
  localparam logic [3:0] StReadW = 4'd7;
  localparam logic [3:0] StDone = 4'd8;
  localparam logic [3:0] StSq = 4'd9;

  logic [7:0] mem [MaxRows*MaxCols];
  logic [7:0] rd_data;
  logic       we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [7:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  logic [3:0] state;
  cmd_t       cmd;
  logic [1:0] seg;
  logic [7:0] h;
  logic [8:0] w;

  // Line walker, signed 13 bits covers all differences.
  logic signed [12:0] lr, lc, er, ec, dr, dc, err;
  logic signed [1:0]  sr, sc;
  // Scan counters.
  logic [RowW:0] si;
  logic [ColW:0] sj;
  logic [RowW:0] i_hi;
  logic [ColW:0] j_lo, j_hi;
  logic          scan_round;
  logic [21:0]   lo_b, hi_b;
  // Distance squared pipeline: offsets, then squares, then the write.
  logic signed [12:0] di, dj;
  logic [23:0] di2, dj2;
  logic [AddrW-1:0] p_addr, p_addr2;
  logic        p_valid, p_valid2;

  assign h = (rows_in_use > 7'(MaxRows)) ? 8'(MaxRows) : {1'b0, rows_in_use};
  assign w = (cols_in_use > 8'(MaxCols)) ? 9'(MaxCols) : {1'b0, cols_in_use};

  function automatic logic on_cv(input logic signed [12:0] r, input logic signed [12:0] c,
                                 input logic [7:0] hh, input logic [8:0] ww);
    return r >= 0 && r < $signed({5'd0, hh}) && c >= 0 && c < $signed({4'd0, ww});
  endfunction

  // Line endpoints for the current segment.
  logic signed [12:0] s_r0, s_c0, s_r1, s_c1;
  always_comb begin
    s_r0 = 13'(cmd.row_a); s_c0 = 13'(cmd.col_a);
    s_r1 = 13'(cmd.row_b); s_c1 = 13'(cmd.col_b);
    if (cmd.mode == ModeRectLine) begin
      case (seg)
        2'd0: begin s_r1 = 13'(cmd.row_a); end
        2'd1: begin s_c1 = 13'(cmd.col_a); end
        2'd2: begin s_r0 = 13'(cmd.row_b); s_c1 = 13'(cmd.col_b); s_c0 = 13'(cmd.col_a); end
        default: begin
          s_r0 = 13'(cmd.row_b); s_c0 = 13'(cmd.col_b);
          s_r1 = 13'(cmd.row_a); s_c1 = 13'(cmd.col_b);
        end
      endcase
    end
  end

  logic signed [13:0] e2;
  logic line_end, step_r, step_c;
  always_comb begin
    e2 = 14'(err) <<< 1;
    line_end = (lr == er) && (lc == ec);
    step_r = (e2 >= 14'(dc)) && (lr != er);
    step_c = (e2 <= 14'(dr)) && (lc != ec);
  end

  logic [23:0] d2;
  assign d2 = di2 + dj2;
  logic last_seg;
  assign last_seg = (cmd.mode != ModeRectLine) || (seg == 2'd3);

  logic rd_hit;
  assign rd_hit = (cmd.mode == ModeRead) && on_cv(13'(cmd.row_a), 13'(cmd.col_a), h, w);

  always_comb begin
    we = 1'b0;
    waddr = {lr[RowW-1:0], lc[ColW-1:0]};
    wdata = cmd.fill_char;
    raddr = {cmd.row_a[RowW-1:0], cmd.col_a[ColW-1:0]};
    q_pop = (state == StIdle) && q_valid;
    unique case (state) inside
      StInit: begin
        we = 1'b1;
        waddr = {si[RowW-1:0], sj[ColW-1:0]};
        wdata = SpaceChar;
      end
      StLine: we = 1'b1;
      StScan, StScanW: begin
        waddr = p_addr2;
        wdata = (cmd.mode == ModeClear) ? SpaceChar : cmd.fill_char;
        we = p_valid2 && (!scan_round || (d2 >= 24'(lo_b) && d2 <= 24'(hi_b)));
      end
      default: ;
    endcase
  end

  logic scan_last;
  assign scan_last = (si == i_hi) && (sj == j_hi);

  always_ff @(posedge clk) begin
    done <= !rst && (state == StDone);
    if (rst) begin
      state <= StInit;
      si <= '0;
      sj <= '0;
      p_valid <= 1'b0;
      p_valid2 <= 1'b0;
      cell_value <= '0;
      cell_in_range <= 1'b0;
    end else begin
      p_valid2 <= p_valid;
      unique case (state)
        StInit: begin
          if (sj == (ColW+1)'(MaxCols - 1)) begin
            sj <= '0;
            if (si == (RowW+1)'(MaxRows - 1)) state <= StIdle;
            else si <= si + 1'b1;
          end else begin
            sj <= sj + 1'b1;
          end
        end
        StIdle: begin
          if (q_valid) begin
            cmd <= q_cmd;
            seg <= 2'd0;
            unique case (q_cmd.mode) inside
              ModeLine, ModeRectLine: state <= StLineSet;
              ModeRing, ModeDisc, ModeRectFill, ModeClear: state <= StSq;
              ModeRead: state <= StRead;
              default: state <= StDone;
            endcase
          end
        end
        StLineSet: begin
          lr <= s_r0; lc <= s_c0; er <= s_r1; ec <= s_c1;
          dr <= (s_r1 > s_r0) ? s_r1 - s_r0 : s_r0 - s_r1;
          dc <= (s_c1 > s_c0) ? s_c0 - s_c1 : s_c1 - s_c0;
          err <= ((s_r1 > s_r0) ? s_r1 - s_r0 : s_r0 - s_r1)
               + ((s_c1 > s_c0) ? s_c0 - s_c1 : s_c1 - s_c0);
          sr <= (s_r0 < s_r1) ? 2'sd1 : -2'sd1;
          sc <= (s_c0 < s_c1) ? 2'sd1 : -2'sd1;
          if (on_cv(s_r0, s_c0, h, w) && on_cv(s_r1, s_c1, h, w)) begin
            state <= StLine;
          end else if (last_seg) begin
            state <= StDone;
          end else begin
            seg <= seg + 1'b1;
          end
        end
        StLine: begin
          if (line_end || (!step_r && !step_c) ||
              ((e2 >= 14'(dc)) && lr == er) || ((e2 <= 14'(dr)) && lc == ec && !step_r)) begin
            if (last_seg) state <= StDone;
            else begin
              seg <= seg + 1'b1;
              state <= StLineSet;
            end
          end else begin
            if (step_r) lr <= lr + 13'(sr);
            if (step_r && step_c) err <= err + dc + dr;
            else if (step_r) err <= err + dc;
            else err <= err + dr;
            if (step_c) begin
              if (!((e2 >= 14'(dc)) && lr == er)) lc <= lc + 13'(sc);
            end
          end
        end
        StSq: begin
          // Bounds of the scan window and circle thresholds.
          scan_round <= (cmd.mode == ModeRing) || (cmd.mode == ModeDisc);
          lo_b <= (cmd.mode == ModeRing) ?
                  22'({12'd0, cmd.radius} * ({12'd0, cmd.radius} - 22'd1)) : 22'd0;
          hi_b <= (cmd.mode == ModeRing) ? 22'({12'd0, cmd.radius} * (cmd.radius + 11'd1))
                                         : 22'({12'd0, cmd.radius} * cmd.radius);
          j_lo <= (cmd.mode == ModeRectFill && cmd.col_a > 0) ? (ColW+1)'(cmd.col_a) : '0;
          i_hi <= (cmd.mode == ModeRectFill && cmd.row_b < $signed({3'd0, h}) - 11'sd1) ?
                  (RowW+1)'(cmd.row_b) : (RowW+1)'(h - 8'd1);
          j_hi <= (cmd.mode == ModeRectFill && cmd.col_b < $signed({2'd0, w}) - 11'sd1) ?
                  (ColW+1)'(cmd.col_b) : (ColW+1)'(w - 9'd1);
          if (h == 8'd0 || w == 9'd0 ||
              (cmd.mode == ModeRectFill &&
               (cmd.row_a > cmd.row_b || cmd.col_a > cmd.col_b ||
                cmd.row_a >= $signed({3'd0, h}) || cmd.col_a >= $signed({2'd0, w}) ||
                cmd.row_b < 0 || cmd.col_b < 0))) begin
            state <= StDone;
          end else begin
            state <= StScan;
            si <= (cmd.mode == ModeRectFill && cmd.row_a > 0) ? (RowW+1)'(cmd.row_a) : '0;
            sj <= (cmd.mode == ModeRectFill && cmd.col_a > 0) ? (ColW+1)'(cmd.col_a) : '0;
            p_valid <= 1'b0;
          end
        end
        StScan: begin
          di <= 13'(si) - 13'(cmd.row_a);
          dj <= 13'(sj) - 13'(cmd.col_a);
          p_addr <= {si[RowW-1:0], sj[ColW-1:0]};
          p_valid <= 1'b1;
          if (scan_last) state <= StScanW;
          else if (sj == j_hi) begin
            sj <= j_lo;
            si <= si + 1'b1;
          end else begin
            sj <= sj + 1'b1;
          end
        end
        StScanW: begin
          // Drain the offset and square stages before finishing.
          p_valid <= 1'b0;
          if (!p_valid) state <= StDone;
        end
        StRead: begin
          state <= StReadW;
        end
        StReadW: begin
          state <= StDone;
        end
        StDone: begin
          cell_value <= rd_hit ? rd_data : '0;
          cell_in_range <= rd_hit;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Squares are registered one stage behind the scan address.
  always_ff @(posedge clk) begin
    di2 <= 24'(di * di);
    dj2 <= 24'(dj * dj);
    p_addr2 <= p_addr;
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> state == StIdle)
    else $error("pop outside idle");
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("double result");
  a_inrange_read: assert property (@(posedge clk) disable iff (rst)
      (done && cell_in_range) |-> cmd.mode == ModeRead)
    else $error("in-range flag on a non-read result");
`endif
endmodule

// ===== design/character_canvas_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Character canvas rasterizer
// Draws lines, circles and rectangles into a 64x128 character canvas.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// command   in         start && !busy
// result    out        done strobe, one cycle
// config    in         cfg_we, cfg_index, cfg_data
//
// A line is stepped cell by cell after a setup state; circles, fill and clear
// scan their window at one cell per cycle, set by the single canvas write
// port, with setup before and a pipeline drain after the scan. A read on an
// idle engine passes through the StRead, StReadW and StDone states before
// its result beat. After reset a clearing pass fills the canvas with spaces.
// Two commands can wait in a queue behind the one in the engine; busy rises
// when both slots are taken. The receiver cannot stall results.
module character_canvas_rasterizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [10:0] row_a,
  input  logic signed [10:0] col_a,
  input  logic signed [10:0] row_b,
  input  logic signed [10:0] col_b,
  input  logic [9:0]         radius,
  input  logic [7:0]         fill_char,
  output logic               done,
  output logic [7:0]         cell_value,
  output logic               cell_in_range,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import ccr_pkg::*;

  cmd_t       cmd_in, q_cmd;
  logic       q_valid, q_pop;
  logic [6:0] rows_in_use;
  logic [7:0] cols_in_use;

  assign cmd_in = '{mode, row_a, col_a, row_b, col_b, radius, fill_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd64;
      cols_in_use <= 8'd128;
    end else if (cfg_we) begin
      if (cfg_index == RegRows) rows_in_use <= cfg_data[6:0];
      else cols_in_use <= cfg_data;
    end
  end

  ccr_front u_front (
    .clk, .rst, .start, .cmd_in, .busy, .q_valid, .q_cmd, .q_pop
  );

  ccr_engine u_engine (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .rows_in_use, .cols_in_use,
    .done, .cell_value, .cell_in_range
  );
endmodule
